// ===== rtl/rls_pkg.sv =====
`timescale 1ns / 1ps
package rls_pkg;

    // fixed field widths of the two channels
    localparam int OP_W       = 2;
    localparam int DEV_W      = 10;
    localparam int FLAGS_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int PORT_W     = 5;
    localparam int TOTAL_W    = 11;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_RECV    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESCHED = 2'd1;
    localparam logic [OP_W-1:0] OP_POP     = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK_N,
        S_LINK_P,
        S_DONE
    } state_t;

    // index of the lowest set bit, x nonzero
    function automatic logic [PORT_W-1:0] low_bit(input logic [FLAGS_W-1:0] x);
        logic [FLAGS_W-1:0] v;
        logic [PORT_W-1:0]  r;
        v = x;
        r = '0;
        if ((v & 32'h0000_FFFF) == '0) begin
            r[4] = 1'b1;
            v = v >> 16;
        end
        if ((v & 32'h0000_00FF) == '0) begin
            r[3] = 1'b1;
            v = v >> 8;
        end
        if ((v & 32'h0000_000F) == '0) begin
            r[2] = 1'b1;
            v = v >> 4;
        end
        if ((v & 32'h0000_0003) == '0) begin
            r[1] = 1'b1;
            v = v >> 2;
        end
        if ((v & 32'h0000_0001) == '0) begin
            r[0] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ready_list_scheduler.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake           tdata fields (lsb first)
// s_        in   s_tvalid/s_tready   opcode[1:0] device_id[11:2] rts_flags[43:12]
// m_        out  m_tvalid/m_tready   status[2:0] out_device[12:3] out_port[17:13]
//                                    ready_total[28:18]
//
// steps per item: S_IDLE and S_DONE only for a pop of an empty list, an
// out-of-range device or an unused opcode; S_IDLE, S_EXEC and S_DONE when no
// neighbor link is written; S_LINK_N or S_LINK_P after S_EXEC when one neighbor
// link is written (append behind a tail, unlink at one end of a longer list);
// both, in that order, for an unlink between two neighbors. the device memory
// has a single write port, so the entry itself, the next link of its predecessor
// and the prev link of its successor are each written in a step of their own.
// after reset a clearing pass over all MAX_DEVICES entries zeroes the ready and
// on-list bits; no item is taken during it.
// the finished result sits in the output register; the next item is taken
// while it waits, and only the result of that item stalls behind it.
module ready_list_scheduler #(
    parameter int MAX_DEVICES = 1024,
    parameter int FLAG_BITS   = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode, device_id, rts_flags, zero fill
    input  logic [rls_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, out_device, out_port, ready_total, zero fill
    output logic [rls_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rls_pkg::*;

    localparam int ADDR_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int LINK_W = $clog2(MAX_DEVICES + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_DEVICES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEVICES - 1);
    localparam logic [FLAGS_W:0]  FLAG_ONE  = (FLAGS_W + 1)'(1) << FLAG_BITS;
    localparam logic [FLAGS_W-1:0] FLAG_MASK = FLAGS_W'(FLAG_ONE - (FLAGS_W + 1)'(1));

    // one memory word per device
    typedef struct packed {
        logic              pv;     // has a chosen port
        logic              ol;     // linked on the ready list
        logic [PORT_W-1:0] port;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] nxt;
    } entry_t;

    entry_t dev_mem [MAX_DEVICES];
    entry_t rd_data_reg;

    state_t state_reg, state_next;

    // list control
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] clr_reg;

    // item context
    logic [OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [DEV_W-1:0]    res_dev_reg;
    logic [PORT_W-1:0]   res_port_reg;

    // pending neighbor link writes
    logic              pfix_en_reg;
    logic [ADDR_W-1:0] nfix_addr_reg, pfix_addr_reg;
    logic [LINK_W-1:0] nfix_val_reg, pfix_val_reg;

    // output register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // input decode
    logic [OP_W-1:0]     in_op;
    logic [DEV_W-1:0]    in_dev;
    logic [FLAGS_W-1:0]  in_flags;
    logic [ADDR_W+DEV_W-1:0] in_dev_ext;
    logic [ADDR_W-1:0]   in_addr;
    logic [LINK_W+DEV_W-1:0] head_ext;
    logic                in_range;
    logic                list_empty;
    logic                need_mem;
    logic                acc;
    logic                out_free;

    assign in_op      = s_tdata[1:0];
    assign in_dev     = s_tdata[11:2];
    assign in_flags   = s_tdata[43:12] & FLAG_MASK;
    assign in_dev_ext = {{ADDR_W{1'b0}}, in_dev};
    assign in_addr    = in_dev_ext[ADDR_W-1:0];
    assign head_ext   = {{DEV_W{1'b0}}, head_reg};
    assign in_range   = 32'(in_dev) < MAX_DEVICES;
    assign list_empty = (head_reg == NULL_LINK) || (count_reg == '0);
    assign need_mem   = (in_op == OP_POP) ? !list_empty
                      : ((in_op == OP_RECV || in_op == OP_RESCHED) && in_range);
    assign acc        = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;

    // memory port controls
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we_full, we_nxt, we_prv;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_entry;
    logic [LINK_W-1:0] wr_link;

    // execute step, decided on the read word
    entry_t              ex_entry;
    logic                ex_write;
    logic                ex_ready;
    logic                ex_unlink;
    logic [PORT_W-1:0]   ex_low;
    logic [STATUS_W-1:0] ex_status;
    logic [PORT_W-1:0]   ex_port;
    logic                ex_nfix, ex_pfix;
    logic [ADDR_W-1:0]   ex_nfix_addr, ex_pfix_addr;
    logic [LINK_W-1:0]   ex_nfix_val, ex_pfix_val;
    logic [LINK_W-1:0]   ex_head, ex_tail, ex_count;
    logic [LINK_W-1:0]   tgt_link;

    assign ex_ready = flags_reg != '0;
    assign ex_low   = low_bit(flags_reg);
    assign tgt_link = LINK_W'(addr_reg);

    always_comb begin
        ex_entry     = rd_data_reg;
        ex_write     = 1'b0;
        ex_unlink    = 1'b0;
        ex_status    = ST_NONE;
        ex_port      = '0;
        ex_nfix      = 1'b0;
        ex_nfix_addr = '0;
        ex_nfix_val  = NULL_LINK;
        ex_pfix      = 1'b0;
        ex_pfix_addr = '0;
        ex_pfix_val  = NULL_LINK;
        ex_head      = head_reg;
        ex_tail      = tail_reg;
        ex_count     = count_reg;
        if (op_reg == OP_POP) begin
            ex_write  = 1'b1;
            ex_unlink = 1'b1;
            ex_status = ST_POPPED;
            ex_port   = rd_data_reg.port;
        end else if (op_reg == OP_RECV && ex_ready == rd_data_reg.pv) begin
            // readiness unchanged: report the stored port, touch nothing
            ex_port = rd_data_reg.pv ? rd_data_reg.port : '0;
        end else if (ex_ready) begin
            ex_write      = 1'b1;
            ex_entry.pv   = 1'b1;
            ex_entry.port = ex_low;
            ex_port       = ex_low;
            if (!rd_data_reg.ol) begin
                // append at the tail
                ex_entry.ol   = 1'b1;
                ex_entry.prev = tail_reg;
                ex_entry.nxt  = NULL_LINK;
                ex_status     = ST_APPENDED;
                if (tail_reg == NULL_LINK) begin
                    ex_head = tgt_link;
                end else begin
                    ex_nfix      = 1'b1;
                    ex_nfix_addr = tail_reg[ADDR_W-1:0];
                    ex_nfix_val  = tgt_link;
                end
                ex_tail  = tgt_link;
                ex_count = count_reg + LINK_W'(1);
            end
        end else begin
            ex_write    = 1'b1;
            ex_entry.pv = 1'b0;
            ex_status   = ST_REMOVED;
            ex_unlink   = rd_data_reg.ol;
        end
        if (ex_unlink) begin
            ex_entry.ol   = 1'b0;
            ex_entry.prev = NULL_LINK;
            ex_entry.nxt  = NULL_LINK;
            if (rd_data_reg.prev != NULL_LINK) begin
                ex_nfix      = 1'b1;
                ex_nfix_addr = rd_data_reg.prev[ADDR_W-1:0];
                ex_nfix_val  = rd_data_reg.nxt;
            end else begin
                ex_head = rd_data_reg.nxt;
            end
            if (rd_data_reg.nxt != NULL_LINK) begin
                ex_pfix      = 1'b1;
                ex_pfix_addr = rd_data_reg.nxt[ADDR_W-1:0];
                ex_pfix_val  = rd_data_reg.prev;
            end else begin
                ex_tail = rd_data_reg.prev;
            end
            if (count_reg != '0) begin
                ex_count = count_reg - LINK_W'(1);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    state_next = need_mem ? S_EXEC : S_DONE;
                end
            end
            S_EXEC: begin
                if (ex_nfix) begin
                    state_next = S_LINK_N;
                end else if (ex_pfix) begin
                    state_next = S_LINK_P;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LINK_N: begin
                state_next = pfix_en_reg ? S_LINK_P : S_DONE;
            end
            S_LINK_P: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // state outputs: handshake and memory port controls
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = (in_op == OP_POP) ? head_reg[ADDR_W-1:0] : in_addr;
        we_full  = 1'b0;
        we_nxt   = 1'b0;
        we_prv   = 1'b0;
        wr_addr  = addr_reg;
        wr_entry = ex_entry;
        wr_link  = nfix_val_reg;
        unique case (state_reg)
            S_CLEAR: begin
                we_full  = 1'b1;
                wr_addr  = clr_reg;
                wr_entry = '0;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                rd_en    = s_tvalid && need_mem;
            end
            S_EXEC: begin
                we_full = ex_write;
            end
            S_LINK_N: begin
                we_nxt  = 1'b1;
                wr_addr = nfix_addr_reg;
                wr_link = nfix_val_reg;
            end
            S_LINK_P: begin
                we_prv  = 1'b1;
                wr_addr = pfix_addr_reg;
                wr_link = pfix_val_reg;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // device memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we_full) begin
            dev_mem[wr_addr] <= wr_entry;
        end else if (we_nxt) begin
            dev_mem[wr_addr].nxt <= wr_link;
        end else if (we_prv) begin
            dev_mem[wr_addr].prev <= wr_link;
        end
        if (rd_en) begin
            rd_data_reg <= dev_mem[rd_addr];
        end
    end

    // list head, tail and count only change in the execute step
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (state_reg == S_EXEC) begin
            head_next  = ex_head;
            tail_next  = ex_tail;
            count_next = ex_count;
        end
    end

    logic [LINK_W+TOTAL_W-1:0] count_ext;
    assign count_ext = {{TOTAL_W{1'b0}}, count_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            head_reg    <= NULL_LINK;
            tail_reg    <= NULL_LINK;
            count_reg   <= '0;
            clr_reg     <= '0;
            pfix_en_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == S_EXEC) begin
                pfix_en_reg <= ex_pfix;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            op_reg         <= in_op;
            addr_reg       <= rd_addr;
            flags_reg      <= in_flags;
            res_port_reg   <= '0;
            res_status_reg <= (in_op == OP_POP && list_empty) ? ST_EMPTY : ST_NONE;
            if (in_op == OP_POP) begin
                res_dev_reg <= list_empty ? '0 : head_ext[DEV_W-1:0];
            end else begin
                res_dev_reg <= in_dev;
            end
        end
        if (state_reg == S_EXEC) begin
            res_status_reg <= ex_status;
            res_port_reg   <= ex_port;
            nfix_addr_reg  <= ex_nfix_addr;
            nfix_val_reg   <= ex_nfix_val;
            pfix_addr_reg  <= ex_pfix_addr;
            pfix_val_reg   <= ex_pfix_val;
        end
        if (state_reg == S_DONE && out_free) begin
            m_data_reg <= {3'b000, count_ext[TOTAL_W-1:0], res_port_reg,
                           res_dev_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/rls_checker.sv =====
`timescale 1ns / 1ps
module rls_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [rls_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rls_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rls_pkg::*;

    logic [STATUS_W-1:0] o_status;
    logic [DEV_W-1:0]    o_dev;
    logic [PORT_W-1:0]   o_port;
    logic [TOTAL_W-1:0]  o_total;

    assign o_status = m_tdata[2:0];
    assign o_dev    = m_tdata[12:3];
    assign o_port   = m_tdata[17:13];
    assign o_total  = m_tdata[28:18];

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty list reports nothing and no ready devices
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_status == ST_EMPTY |-> o_total == '0 && o_dev == '0 && o_port == '0)
        else $error("empty pop with nonzero fields");

    // an append leaves at least one device on the list
    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_status == ST_APPENDED |-> o_total != '0)
        else $error("append with empty list");

    // a removal carries no port
    a_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_status == ST_REMOVED |-> o_port == '0)
        else $error("removal with a port");

endmodule

bind ready_list_scheduler rls_checker u_rls_checker (.*);
